// File: design/sprle_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the sprite run-length scanline decoder.
// No dependencies; imported by every module of the block.
package sprle_pkg;

  localparam int DIM_W      = 9;            // frame_width / frame_height registers
  localparam int ROW_BASE_W = 2 * DIM_W;    // row * width
  localparam int COL_W      = 17;
  localparam int LIT_W      = 7;
  localparam int ADDR_W     = ROW_BASE_W + 1;
  localparam int PIX_ADDR_W = 16;
  localparam int BYTE_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [BYTE_W-1:0] CTRL_EOL   = 8'h80;
  localparam logic [LIT_W-1:0]  RUN_MASK   = 7'h7F;
  localparam logic [COL_W-1:0]  COLUMN_MAX = '1;

  localparam logic [STATUS_W-1:0] ST_CONTROL = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PIXEL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERRUN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BOUNDS  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;

  typedef struct packed {
    logic [COL_W-1:0]      column;
    logic [DIM_W-1:0]      row;
    logic [ROW_BASE_W-1:0] row_base;
    logic [LIT_W-1:0]      literal_left;
    logic                  active;
  } dec_state_t;

  typedef struct packed {
    logic [DIM_W-1:0]      eff_w;
    logic [DIM_W-1:0]      eff_h;
    logic [ROW_BASE_W-1:0] limit;
  } frame_geom_t;

endpackage

// File: design/sprite_rle_scanline_decoder_unit.sv
`timescale 1ns / 1ps
// Sprite run-length scanline decoder: takes one coded byte per cycle unless the result
// stalls and returns one result per byte, through an input register and a result register.
// Throughput is one byte per cycle when not stalled, set by the single-pass decode between
// the two registers (one small dimension multiplier and the address add and bounds compare).
// Depends on sprle_pkg, sprle_cfg and sprle_step.
module sprite_rle_scanline_decoder_unit
  import sprle_pkg::*;
#(
  parameter int MAX_DIM     = 256,
  parameter int LENGTH_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     coded_byte,
  input  logic                  frame_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   status,
  output logic [PIX_ADDR_W-1:0] pixel_address,
  output logic [BYTE_W-1:0]     pixel_value
);

  localparam int LEN_W = (LENGTH_BITS < CFG_DATA_W) ? LENGTH_BITS : CFG_DATA_W;

  frame_geom_t           geom;
  logic [LEN_W-1:0]      data_length;

  logic                  hold_valid;
  logic [BYTE_W-1:0]     hold_byte;
  logic                  hold_start;
  logic                  hold_fire;

  dec_state_t            state;
  dec_state_t            state_next;
  logic [LEN_W-1:0]      bytes_taken;
  logic [LEN_W-1:0]      bytes_taken_next;
  logic [STATUS_W-1:0]   status_next;
  logic [PIX_ADDR_W-1:0] pixel_address_next;
  logic [BYTE_W-1:0]     pixel_value_next;

  sprle_cfg #(.MAX_DIM(MAX_DIM), .LEN_W(LEN_W)) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .geom        (geom),
    .data_length (data_length)
  );

  sprle_step #(.LEN_W(LEN_W)) u_step (
    .state            (state),
    .bytes_taken      (bytes_taken),
    .data_length      (data_length),
    .geom             (geom),
    .coded_byte       (hold_byte),
    .frame_start      (hold_start),
    .state_next       (state_next),
    .bytes_taken_next (bytes_taken_next),
    .status_code      (status_next),
    .addr             (pixel_address_next),
    .value            (pixel_value_next)
  );

  // advance the held request whenever the result register is free or draining
  assign hold_fire = hold_valid && (!out_valid || out_ready);
  assign in_ready  = !hold_valid || hold_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte  <= coded_byte;
      hold_start <= frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= '0;
      bytes_taken <= '0;
    end else if (hold_fire) begin
      state       <= state_next;
      bytes_taken <= bytes_taken_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hold_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_fire) begin
      status        <= status_next;
      pixel_address <= pixel_address_next;
      pixel_value   <= pixel_value_next;
    end
  end

endmodule

// File: design/sprle_cfg.sv
`timescale 1ns / 1ps
// Configuration registers with clamped frame dimensions and pixel limit.
// Depends on sprle_pkg.
module sprle_cfg
  import sprle_pkg::*;
#(
  parameter int MAX_DIM = 256,
  parameter int LEN_W   = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output frame_geom_t           geom,
  output logic [LEN_W-1:0]      data_length
);

  localparam logic [DIM_W-1:0] DIM_CAP = (MAX_DIM >= (1 << DIM_W)) ? '1 : DIM_W'(MAX_DIM);

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(1);
      frame_height <= DIM_W'(1);
      data_length  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        REG_LENGTH: data_length  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > DIM_CAP) return DIM_CAP;
    return v;
  endfunction

  always_comb begin
    geom.eff_w = clamp_dim(frame_width);
    geom.eff_h = clamp_dim(frame_height);
    geom.limit = geom.eff_w * geom.eff_h;
  end

endmodule

// File: design/sprle_step.sv
`timescale 1ns / 1ps
// Per-byte decode: next decoder state and the result for one coded byte.
// Depends on sprle_pkg.
module sprle_step
  import sprle_pkg::*;
#(
  parameter int LEN_W = 24
) (
  input  dec_state_t            state,
  input  logic [LEN_W-1:0]      bytes_taken,
  input  logic [LEN_W-1:0]      data_length,
  input  frame_geom_t           geom,
  input  logic [BYTE_W-1:0]     coded_byte,
  input  logic                  frame_start,
  output dec_state_t            state_next,
  output logic [LEN_W-1:0]      bytes_taken_next,
  output logic [STATUS_W-1:0]   status_code,
  output logic [PIX_ADDR_W-1:0] addr,
  output logic [BYTE_W-1:0]     value
);

  dec_state_t            cur;
  logic [LEN_W-1:0]      bytes_cur;
  logic [COL_W:0]        col_sum;
  logic [ADDR_W-1:0]     addr_sum;
  logic [DIM_W-1:0]      mul_row;
  logic [ROW_BASE_W-1:0] product;
  logic                  eol_step;

  always_comb begin
    cur       = state;
    bytes_cur = bytes_taken;
    if (frame_start) begin
      cur.column       = '0;
      cur.row          = geom.eff_h - DIM_W'(1);
      cur.literal_left = '0;
      cur.active       = 1'b1;
      bytes_cur        = '0;
    end

    state_next       = cur;
    bytes_taken_next = bytes_cur;
    status_code      = ST_IGNORED;
    addr             = '0;
    value            = '0;
    eol_step         = 1'b0;

    col_sum  = {1'b0, cur.column} + (COL_W + 1)'(coded_byte[LIT_W-1:0]);
    addr_sum = ADDR_W'(cur.row_base) + ADDR_W'(cur.column);

    if (!cur.active) begin
      status_code = ST_IGNORED;
    end else if (bytes_cur >= data_length) begin
      status_code       = ST_OVERRUN;
      state_next.active = 1'b0;
    end else begin
      if (bytes_cur != '1) bytes_taken_next = bytes_cur + LEN_W'(1);
      if (cur.literal_left != '0) begin
        if (addr_sum >= ADDR_W'(geom.limit)) begin
          status_code       = ST_BOUNDS;
          state_next.active = 1'b0;
        end else begin
          status_code             = ST_PIXEL;
          addr                    = addr_sum[PIX_ADDR_W-1:0];
          value                   = coded_byte;
          state_next.literal_left = cur.literal_left - LIT_W'(1);
          if (cur.column != COLUMN_MAX) state_next.column = cur.column + COL_W'(1);
        end
      end else if (coded_byte == CTRL_EOL) begin
        if (cur.row == '0) begin
          status_code       = ST_DONE;
          state_next.active = 1'b0;
        end else begin
          status_code       = ST_CONTROL;
          eol_step          = 1'b1;
          state_next.row    = cur.row - DIM_W'(1);
          state_next.column = '0;
        end
      end else if (coded_byte[BYTE_W-1]) begin
        status_code       = ST_CONTROL;
        // skip transparent pixels, saturating the column
        state_next.column = col_sum[COL_W] ? COLUMN_MAX : col_sum[COL_W-1:0];
      end else begin
        status_code             = ST_CONTROL;
        state_next.literal_left = coded_byte[LIT_W-1:0] & RUN_MASK;
      end
    end

    // one multiplier serves both frame start and line end
    mul_row = eol_step ? cur.row - DIM_W'(1) : cur.row;
    product = mul_row * geom.eff_w;
    if (frame_start || eol_step) state_next.row_base = product;
  end

endmodule

// File: design/sprle_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the decoder, attached to the top level by bind.
// Depends on sprle_pkg and sprite_rle_scanline_decoder_unit.
module sprle_checker
  import sprle_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [STATUS_W-1:0]   status,
  input logic [PIX_ADDR_W-1:0] pixel_address,
  input logic [BYTE_W-1:0]     pixel_value
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({status, pixel_address, pixel_value}))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  a_no_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_PIXEL |-> pixel_address == '0 && pixel_value == '0)
    else $error("address or value set on a non-pixel result");

  // a request taken behind a stalled result fills both stages, so input ready then follows out_ready
  a_skid_full: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && out_valid && !out_ready |=> in_ready == out_ready)
    else $error("input ready wrong with both stages full");

endmodule

bind sprite_rle_scanline_decoder_unit sprle_checker u_sprle_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .pixel_address (pixel_address),
  .pixel_value   (pixel_value)
);
